// ===== src/toeq_pkg.sv =====
// ----------------------------------------------------------------------------
// toeq_pkg: shared types and constants of the time ordered expiry queue
// Field widths, operation and status codes, and the expire burst limit.
// ----------------------------------------------------------------------------
package toeq_pkg;

  localparam int unsigned OpW     = 3;
  localparam int unsigned IdW     = 16;
  localparam int unsigned TimeW   = 16;
  localparam int unsigned ElapseW = 15;
  localparam int unsigned StatusW = 3;

  // Most entries removed by one expire transaction
  localparam int unsigned MaxResults = 16;
  localparam int unsigned NexpW      = $clog2(MaxResults + 1);

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 3'd0,
    OP_POP    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_QUERY  = 3'd3,
    OP_ELAPSE = 3'd4,
    OP_EXPIRE = 3'd5
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_NONE     = 3'd4
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic load;  // capture the accepted request
    logic exec;  // perform one step and load the result register
  } toeq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic res_last;  // the step under way produces the final result
  } toeq_stat_t;

endpackage

// ===== src/toeq_if.sv =====
// ----------------------------------------------------------------------------
// toeq_req_if / toeq_rsp_if: request and response channels
// Valid/ready channels carrying one request or one result per transaction.
// ----------------------------------------------------------------------------
interface toeq_req_if import toeq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OpW-1:0]           op;
  logic [IdW-1:0]           item_id;
  logic signed [TimeW-1:0]  item_time;
  logic [ElapseW-1:0]       elapsed;

  modport source (output valid, op, item_id, item_time, elapsed, input ready);
  modport sink   (input valid, op, item_id, item_time, elapsed, output ready);
endinterface

interface toeq_rsp_if import toeq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [StatusW-1:0]       status;
  logic [IdW-1:0]           out_id;
  logic signed [TimeW-1:0]  out_time;
  logic                     found;
  logic                     last;

  modport source (output valid, status, out_id, out_time, found, last, input ready);
  modport sink   (input valid, status, out_id, out_time, found, last, output ready);
endinterface

// ===== src/toeq_dpath.sv =====
// ----------------------------------------------------------------------------
// toeq_dpath: shifting cell row and result register
// Holds the sorted entries in a row of cells that shift in parallel, and
// forms one result per step.
// ----------------------------------------------------------------------------
module toeq_dpath import toeq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  toeq_cmd_t               cmd_i,
  output toeq_stat_t              stat_o,
  input  logic [OpW-1:0]          op_i,
  input  logic [IdW-1:0]          item_id_i,
  input  logic signed [TimeW-1:0] item_time_i,
  input  logic [ElapseW-1:0]      elapsed_i,
  output logic [StatusW-1:0]      status_o,
  output logic [IdW-1:0]          out_id_o,
  output logic signed [TimeW-1:0] out_time_o,
  output logic                    found_o,
  output logic                    last_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // Captured request
  logic [OpW-1:0]          op_q;
  logic [IdW-1:0]          id_q;
  logic signed [TimeW-1:0] time_q;
  logic [ElapseW-1:0]      el_q;

  // Entry row and counters
  logic [IdW-1:0]          cell_id_q   [DEPTH];
  logic signed [TimeW-1:0] cell_time_q [DEPTH];
  logic [IdW-1:0]          cell_id_d   [DEPTH];
  logic signed [TimeW-1:0] cell_time_d [DEPTH];
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [NexpW-1:0]        nexp_q, nexp_d;

  // Result register
  logic [StatusW-1:0]      status_q, status_d;
  logic [IdW-1:0]          out_id_q, out_id_d;
  logic signed [TimeW-1:0] out_time_q, out_time_d;
  logic                    found_q, found_d;
  logic                    last_q, last_d;

  logic [DEPTH-1:0] occ, le, match, after_match;
  logic             full, empty, any_match, head_exp, next_exp, wr_cells;

  // Per-cell compares
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occ[i]   = CntW'(i) < cnt_q;
      le[i]    = occ[i] && (cell_time_q[i] <= time_q);
      match[i] = occ[i] && (cell_id_q[i] == id_q);
    end
  end

  // Mark cells at or after the first matching id
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      after_match[i] = 1'b0;
      for (int j = 0; j <= i; j++) begin
        after_match[i] = after_match[i] | match[j];
      end
    end
  end

  assign full      = cnt_q == CntW'(DEPTH);
  assign empty     = cnt_q == '0;
  assign any_match = |match;
  assign head_exp  = !empty && (cell_time_q[0] <= 16'sd0) &&
                     (nexp_q < NexpW'(MaxResults));
  assign next_exp  = (cnt_q > CntW'(1)) && (cell_time_q[1] <= 16'sd0);

  // Next value of every cell
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [IdW-1:0]          ins_id, nxt_id;
    logic signed [TimeW-1:0] ins_time, nxt_time;
    logic [TimeW:0]          diff;
    logic                    shift;

    if (g == 0) begin : g_first
      assign ins_id   = id_q;
      assign ins_time = time_q;
    end else begin : g_rest
      assign ins_id   = le[g-1] ? id_q : cell_id_q[g-1];
      assign ins_time = le[g-1] ? time_q : cell_time_q[g-1];
    end

    if (g < DEPTH - 1) begin : g_has_next
      assign nxt_id   = cell_id_q[g+1];
      assign nxt_time = cell_time_q[g+1];
    end else begin : g_tail
      assign nxt_id   = cell_id_q[g];
      assign nxt_time = cell_time_q[g];
    end

    assign diff  = {cell_time_q[g][TimeW-1], cell_time_q[g]} - {2'b00, el_q};
    assign shift = (op_q == OP_REMOVE) ? after_match[g] : 1'b1;

    always_comb begin
      cell_id_d[g]   = cell_id_q[g];
      cell_time_d[g] = cell_time_q[g];
      unique case (op_q)
        OP_INSERT: begin
          if (!le[g]) begin
            cell_id_d[g]   = ins_id;
            cell_time_d[g] = ins_time;
          end
        end
        OP_POP, OP_REMOVE, OP_EXPIRE: begin
          if (shift) begin
            cell_id_d[g]   = nxt_id;
            cell_time_d[g] = nxt_time;
          end
        end
        OP_ELAPSE: begin
          // Saturate at the most negative time
          if (diff[TimeW] && !diff[TimeW-1]) begin
            cell_time_d[g] = {1'b1, {(TimeW-1){1'b0}}};
          end else begin
            cell_time_d[g] = diff[TimeW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Result and state change of one step
  always_comb begin
    status_d   = ST_OK;
    out_id_d   = '0;
    out_time_d = '0;
    found_d    = 1'b0;
    last_d     = 1'b1;
    cnt_d      = cnt_q;
    nexp_d     = nexp_q;
    wr_cells   = 1'b0;
    unique case (op_q)
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          wr_cells = 1'b1;
          cnt_d    = cnt_q + CntW'(1);
        end
      end
      OP_POP: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          out_id_d   = cell_id_q[0];
          out_time_d = cell_time_q[0];
          wr_cells   = 1'b1;
          cnt_d      = cnt_q - CntW'(1);
        end
      end
      OP_REMOVE: begin
        if (!any_match) begin
          status_d = ST_NOTFOUND;
        end else begin
          wr_cells = 1'b1;
          cnt_d    = cnt_q - CntW'(1);
        end
      end
      OP_QUERY: begin
        found_d = any_match;
      end
      OP_ELAPSE: begin
        wr_cells = 1'b1;
      end
      OP_EXPIRE: begin
        if (head_exp) begin
          out_id_d   = cell_id_q[0];
          out_time_d = cell_time_q[0];
          wr_cells   = 1'b1;
          cnt_d      = cnt_q - CntW'(1);
          nexp_d     = nexp_q + NexpW'(1);
          last_d     = !(next_exp && (nexp_q < NexpW'(MaxResults - 1)));
        end else begin
          status_d = ST_NONE;
        end
      end
      default: ;
    endcase
  end

  assign stat_o.res_last = last_d;

  // Control registers: fill count and expire burst count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      nexp_q <= '0;
    end else if (cmd_i.load) begin
      nexp_q <= '0;
    end else if (cmd_i.exec) begin
      cnt_q  <= cnt_d;
      nexp_q <= nexp_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      id_q   <= item_id_i;
      time_q <= item_time_i;
      el_q   <= elapsed_i;
    end
    if (cmd_i.exec) begin
      status_q   <= status_d;
      out_id_q   <= out_id_d;
      out_time_q <= out_time_d;
      found_q    <= found_d;
      last_q     <= last_d;
    end
    if (cmd_i.exec && wr_cells) begin
      for (int i = 0; i < DEPTH; i++) begin
        cell_id_q[i]   <= cell_id_d[i];
        cell_time_q[i] <= cell_time_d[i];
      end
    end
  end

  assign status_o   = status_q;
  assign out_id_o   = out_id_q;
  assign out_time_o = out_time_q;
  assign found_o    = found_q;
  assign last_o     = last_q;

endmodule

// ===== src/toeq_ctrl.sv =====
// ----------------------------------------------------------------------------
// toeq_ctrl: sequencing controller
// Takes one request at a time, steps the datapath once per result and
// holds the response valid until the result is taken.
// ----------------------------------------------------------------------------
module toeq_ctrl import toeq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  toeq_stat_t stat_i,
  output toeq_cmd_t  cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // The result register is free when empty or being taken this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = state_q == S_IDLE;

  assign cmd_o.load = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.exec = (state_q == S_EXEC) && out_free;

  // Next state and response valid
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (stat_i.res_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/time_ordered_expiry_queue.sv =====
// An accepted request is captured in the request registers; each execute step then
// loads one result into the result register once that register is free, and the
// further entries of an expire follow at one result per cycle while results are taken.
// Each result comes from the single execute step of the shifting cell row, and no new
// request is taken until the final result of the current one has been formed.
// Reset: asynchronous, active low; the queue is empty after reset.
// ----------------------------------------------------------------------------
// time_ordered_expiry_queue: top level
// Sorted queue of (id, time) entries with insert, pop, remove, query,
// elapse and expire transactions.
// ----------------------------------------------------------------------------
module time_ordered_expiry_queue import toeq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  toeq_req_if.sink          req_i,
  toeq_rsp_if.source        rsp_o
);

  toeq_cmd_t  cmd;
  toeq_stat_t stat;

  // Sequencing
  toeq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Entry storage and result forming
  toeq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .op_i        (req_i.op),
    .item_id_i   (req_i.item_id),
    .item_time_i (req_i.item_time),
    .elapsed_i   (req_i.elapsed),
    .status_o    (rsp_o.status),
    .out_id_o    (rsp_o.out_id),
    .out_time_o  (rsp_o.out_time),
    .found_o     (rsp_o.found),
    .last_o      (rsp_o.last)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for time_ordered_expiry_queue
// Drives insert, pop, remove, query, elapse and expire transactions with
// random idling on both channels. A shadow timer list predicts every result,
// and each returned result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
  import toeq_pkg::*;

  localparam int unsigned Depth         = 16;
  localparam int unsigned RandomItems   = 190;
  localparam int unsigned HoldOffCycles = 150;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles   = 20;

  // Op codes the block treats as no-ops
  localparam logic [OpW-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OpW-1:0] OP_RSVD7 = 3'd7;

  typedef struct {
    logic [IdW-1:0]          id;
    logic signed [TimeW-1:0] tm;
  } timer_t;

  typedef struct {
    status_e                 status;
    logic [IdW-1:0]          id;
    logic signed [TimeW-1:0] tm;
    logic                    found;
    logic                    last;
  } rsp_t;

  logic clk_i;
  logic rst_ni;

  toeq_req_if req ();
  toeq_rsp_if rsp ();

  time_ordered_expiry_queue #(
    .DEPTH(Depth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  // Shadow copy of the queue and the results still owed by the block
  timer_t timers[$];
  rsp_t   awaited_rsp[$];

  bit tx_no_idle;
  bit rx_no_idle;
  bit hold_off_req;
  int stall_left;
  int err_cnt;
  int idle_cycles;
  int n_sent;
  int n_checked;
  int n_expired;
  int n_full;
  int n_saturated;
  int n_hold_offs;

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len(bit off);
    int r;
    if (off) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void owe(status_e st, logic [IdW-1:0] id,
                              logic signed [TimeW-1:0] tm, logic found, logic last);
    rsp_t r;
    r.status = st;
    r.id     = id;
    r.tm     = tm;
    r.found  = found;
    r.last   = last;
    awaited_rsp.push_back(r);
  endfunction

  function automatic int find_timer(logic [IdW-1:0] id);
    foreach (timers[i])
      if (timers[i].id == id) return i;
    return -1;
  endfunction

  // Apply one accepted transaction to the shadow queue and owe its results
  function automatic void advance_timers(logic [OpW-1:0] op, logic [IdW-1:0] id,
                                         logic signed [TimeW-1:0] tm,
                                         logic [ElapseW-1:0] el);
    int     pos;
    int     v;
    int     n;
    timer_t t;
    case (op)
      OP_INSERT: begin
        if (timers.size() >= Depth) begin
          owe(ST_FULL, '0, '0, 1'b0, 1'b1);
          n_full++;
        end else begin
          // equal times keep arrival order
          pos = 0;
          while (pos < timers.size() && timers[pos].tm <= tm) pos++;
          t.id = id;
          t.tm = tm;
          timers.insert(pos, t);
          owe(ST_OK, '0, '0, 1'b0, 1'b1);
        end
      end
      OP_POP: begin
        if (timers.size() == 0) begin
          owe(ST_EMPTY, '0, '0, 1'b0, 1'b1);
        end else begin
          owe(ST_OK, timers[0].id, timers[0].tm, 1'b0, 1'b1);
          void'(timers.pop_front());
        end
      end
      OP_REMOVE: begin
        pos = find_timer(id);
        if (pos < 0) begin
          owe(ST_NOTFOUND, '0, '0, 1'b0, 1'b1);
        end else begin
          timers.delete(pos);
          owe(ST_OK, '0, '0, 1'b0, 1'b1);
        end
      end
      OP_QUERY: begin
        owe(ST_OK, '0, '0, find_timer(id) >= 0, 1'b1);
      end
      OP_ELAPSE: begin
        // clamp at the most negative time
        foreach (timers[i]) begin
          v = int'(timers[i].tm) - int'(el);
          if (v < -32768) begin
            v = -32768;
            n_saturated++;
          end
          timers[i].tm = TimeW'(v);
        end
        owe(ST_OK, '0, '0, 1'b0, 1'b1);
      end
      OP_EXPIRE: begin
        n = 0;
        while (n < MaxResults && timers.size() > 0 && timers[0].tm <= 0) begin
          owe(ST_OK, timers[0].id, timers[0].tm, 1'b0, 1'b0);
          void'(timers.pop_front());
          n++;
        end
        if (n == 0) begin
          owe(ST_NONE, '0, '0, 1'b0, 1'b1);
        end else begin
          awaited_rsp[$].last = 1'b1;
          n_expired += n;
        end
      end
      default: begin
        owe(ST_OK, '0, '0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  // Offer one request, hold it until accepted, then predict its results
  task automatic send_item(logic [OpW-1:0] op, logic [IdW-1:0] id,
                           logic signed [TimeW-1:0] tm, logic [ElapseW-1:0] el);
    int gap;
    gap = idle_len(tx_no_idle);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid     <= 1'b1;
    req.op        <= op;
    req.item_id   <= id;
    req.item_time <= tm;
    req.elapsed   <= el;
    do @(posedge clk_i); while (!req.ready);
    advance_timers(op, id, tm, el);
    n_sent++;
  endtask

  // Pick an id that is queued most of the time, otherwise any id
  function automatic logic [IdW-1:0] pick_id();
    if (timers.size() > 0 && $urandom_range(0, 3) != 0)
      return timers[$urandom_range(0, timers.size() - 1)].id;
    return IdW'($urandom_range(0, 65535));
  endfunction

  // Random mix weighted towards inserts, elapses and expires
  task automatic send_random_mix(int count);
    int                      r;
    int                      t;
    logic [OpW-1:0]          op;
    logic [IdW-1:0]          id;
    logic signed [TimeW-1:0] tm;
    logic [ElapseW-1:0]      el;
    repeat (count) begin
      id = IdW'($urandom_range(0, 65535));
      tm = TimeW'($urandom_range(0, 65535));
      el = ElapseW'($urandom_range(0, 32767));
      r  = $urandom_range(0, 99);
      if (r < 36) begin
        op = OP_INSERT;
        // a small id pool gives duplicate ids
        if ($urandom_range(0, 1) == 0) id = IdW'($urandom_range(0, 31));
        if ($urandom_range(0, 9) != 0) begin
          t  = int'($urandom_range(0, 300)) - 40;
          tm = TimeW'(t);
        end
      end else if (r < 50) begin
        op = OP_ELAPSE;
        if ($urandom_range(0, 7) != 0) el = ElapseW'($urandom_range(0, 60));
      end else if (r < 66) begin
        op = OP_EXPIRE;
      end else if (r < 76) begin
        op = OP_POP;
      end else if (r < 86) begin
        op = OP_REMOVE;
        id = pick_id();
      end else if (r < 96) begin
        op = OP_QUERY;
        id = pick_id();
      end else begin
        op = ($urandom_range(0, 1) == 0) ? OP_RSVD6 : OP_RSVD7;
      end
      send_item(op, id, tm, el);
    end
  endtask

  // Empty queue: pop, expire, remove and query all miss; unknown op is a no-op
  task automatic test_empty_queue();
    send_item(OP_POP, 16'hFFFF, -16'sd1, 15'h7FFF);
    send_item(OP_EXPIRE, 16'h0000, 16'sh7FFF, 15'h0000);
    send_item(OP_REMOVE, 16'h0000, 16'sh0000, 15'h0000);
    send_item(OP_QUERY, 16'hFFFF, 16'sh8000, 15'h7FFF);
    send_item(OP_RSVD6, 16'hA5A5, 16'sh5A5A, 15'h2AAA);
  endtask

  // Fill to capacity with extreme and tied times, overflow, then drain
  task automatic test_fill_and_drain();
    logic signed [TimeW-1:0] fill_tm [Depth] = '{
      16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0, 16'sd5, -16'sd5, 16'sd100, 16'sd0,
      16'sh8000, 16'sh7FFF, 16'sd1, -16'sd1, 16'sd20, 16'sd20, 16'sd7, 16'sd3
    };
    logic [IdW-1:0] fill_id [Depth] = '{
      16'h0000, 16'h0001, 16'h0042, 16'h1234, 16'h4000, 16'h8000, 16'h00FF, 16'h0042,
      16'hFF00, 16'h7FFF, 16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0, 16'h3C3C, 16'hFFFF
    };
    for (int i = 0; i < Depth; i++)
      send_item(OP_INSERT, fill_id[i], fill_tm[i], 15'h0000);
    send_item(OP_INSERT, 16'h0BAD, 16'sd0, 15'h0000);
    send_item(OP_QUERY, 16'hFFFF, 16'sh0000, 15'h0000);
    // duplicate id: only the first occurrence goes
    send_item(OP_REMOVE, 16'h0042, 16'sh0000, 15'h0000);
    send_item(OP_POP, 16'h0000, 16'sh0000, 15'h0000);
    send_item(OP_ELAPSE, 16'h0000, 16'sh0000, 15'd10);
    send_item(OP_EXPIRE, 16'h0000, 16'sh0000, 15'h0000);
    send_item(OP_ELAPSE, 16'h0000, 16'sh0000, 15'h7FFF);
    send_item(OP_EXPIRE, 16'h0000, 16'sh0000, 15'h0000);
  endtask

  task automatic test_random_traffic();
    send_random_mix(RandomItems);
  endtask

  // Hold off the result side for a long stretch while requests keep coming
  task automatic test_output_stall();
    tx_no_idle   = 1'b1;
    hold_off_req = 1'b1;
    repeat (12)
      send_item(OP_INSERT, IdW'($urandom_range(0, 65535)),
                TimeW'($urandom_range(0, 200)), 15'h0000);
    send_item(OP_ELAPSE, 16'h0000, 16'sh0000, 15'd400);
    send_item(OP_EXPIRE, 16'h0000, 16'sh0000, 15'h0000);
    tx_no_idle = 1'b0;
  endtask

  // Full rate on both sides
  task automatic test_back_to_back();
    tx_no_idle = 1'b1;
    rx_no_idle = 1'b1;
    send_random_mix(30);
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  // Result side ready: random stalls, the long hold-off on request
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      int gap;
      @(posedge clk_i);
      if (!rst_ni) begin
        rsp.ready <= 1'b0;
      end else if (hold_off_req) begin
        rsp.ready    <= 1'b0;
        stall_left   = HoldOffCycles - 1;
        hold_off_req = 1'b0;
        n_hold_offs++;
      end else if (stall_left > 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else begin
        gap = idle_len(rx_no_idle);
        if (gap == 0) begin
          rsp.ready <= 1'b1;
        end else begin
          rsp.ready  <= 1'b0;
          stall_left = gap - 1;
        end
      end
    end
  end

  // Compare each accepted result with the oldest one owed
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (awaited_rsp.size() == 0) begin
        $error("unexpected result: status %0d out_id %0d out_time %0d",
               rsp.status, rsp.out_id, rsp.out_time);
        err_cnt++;
      end else begin
        want = awaited_rsp.pop_front();
        n_checked++;
        if (rsp.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, rsp.status);
          err_cnt++;
        end
        if (rsp.out_id !== want.id) begin
          $error("out_id mismatch: expected %0d, actual %0d", want.id, rsp.out_id);
          err_cnt++;
        end
        if (rsp.out_time !== want.tm) begin
          $error("out_time mismatch: expected %0d, actual %0d", want.tm, rsp.out_time);
          err_cnt++;
        end
        if (rsp.found !== want.found) begin
          $error("found mismatch: expected %0d, actual %0d", want.found, rsp.found);
          err_cnt++;
        end
        if (rsp.last !== want.last) begin
          $error("last mismatch: expected %0d, actual %0d", want.last, rsp.last);
          err_cnt++;
        end
      end
    end
  end

  // Abort when no transaction moves on either channel for too long
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Reset, run the tests in turn, drain and report
  initial begin
    rst_ni        <= 1'b0;
    req.valid     <= 1'b0;
    req.op        <= OP_INSERT;
    req.item_id   <= '0;
    req.item_time <= '0;
    req.elapsed   <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_queue();
    test_fill_and_drain();
    test_random_traffic();
    test_output_stall();
    test_back_to_back();
    req.valid <= 1'b0;

    while (awaited_rsp.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("tb: %0d requests sent, %0d results checked, %0d entries expired",
             n_sent, n_checked, n_expired);
    $display("tb: %0d inserts refused when full, %0d times clamped, %0d output hold-offs",
             n_full, n_saturated, n_hold_offs);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
